### rtl/avfc_pkg.sv
package avfc_pkg;

  localparam int BLK_W      = 128;
  localparam int HALF_W     = 64;
  localparam int CFG_IDX_W  = 8;
  localparam int NUM_RK     = 11;
  localparam int RK_AW      = 4;
  localparam logic [RK_AW-1:0] LAST_RND = RK_AW'(NUM_RK - 1);
  localparam logic [7:0] FIELD_LOW = 8'h2D;
  localparam logic [7:0] FWD_AFF   = 8'h63;
  localparam logic [7:0] INV_AFF   = 8'h05;
  localparam logic [7:0] RCON_INIT = 8'h01;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WHITEN,
    ST_ROUND,
    ST_OUT
  } st_t;

  typedef struct packed {
    logic             en;
    logic [RK_AW-1:0] addr;
    logic [BLK_W-1:0] data;
  } rk_wr_t;

  typedef logic [7:0] sbox_tab_t [256];

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? FIELD_LOW : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = xtime(x);
    end
    return r;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h01;
    p = a;
    for (int i = 0; i < 7; i++) begin
      p = gf_mul(p, p);
      r = gf_mul(r, p);
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
    return 8'((x << n) | (x >> (8 - n)));
  endfunction

  function automatic sbox_tab_t gen_sbox(input logic inv);
    sbox_tab_t t;
    logic [7:0] x;
    logic [7:0] y;
    for (int i = 0; i < 256; i++) begin
      x = 8'(i);
      if (!inv) begin
        y = gf_inv(x);
        t[i] = y ^ rotl8(y, 1) ^ rotl8(y, 2) ^ rotl8(y, 3) ^ rotl8(y, 4) ^ FWD_AFF;
      end else begin
        t[i] = gf_inv(rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ INV_AFF);
      end
    end
    return t;
  endfunction

  localparam sbox_tab_t FWD_SBOX = gen_sbox(1'b0);
  localparam sbox_tab_t REV_SBOX = gen_sbox(1'b1);

endpackage

### rtl/avfc_if.sv
interface avfc_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, op, block_high, block_low, input ready);
  modport sink   (input valid, op, block_high, block_low, output ready);
endinterface

interface avfc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface avfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/aes128_variant_field_cipher_unit.sv
// AES-128 style block cipher with every GF(2^8) operation reduced by 0x12D.
// Write key_high (index 0) and key_low (index 1) through the cfg port first;
// each write expands the eleven round keys, during which no request is
// taken. A request (op 0 encrypt, op 1 decrypt) then goes through these
// steps: the first round key is fetched on the accepting edge, then a
// whitening step, ten rounds through the single shared round unit (one
// round per cycle, keys read from the round key RAM a round ahead), and
// a move of the result into the output register once that register is
// free or being read. The block takes one request at a time; the next
// request is taken only after the previous one has reached the output
// register, and a new request may be accepted while a result still waits.
module aes128_variant_field_cipher_unit (
  input  logic       clk,
  input  logic       rst_n,
  avfc_in_if.sink    in_req,
  avfc_out_if.source out_rsp,
  avfc_cfg_if.sink   cfg_wr
);
  import avfc_pkg::*;

  st_t              st_r, st_nxt;
  logic             dec_r;
  logic [RK_AW-1:0] rnd_r, rnd_nxt;
  logic [BLK_W-1:0] blk_r;
  logic             out_valid_r;
  logic [BLK_W-1:0] out_data_r;

  rk_wr_t           rk_wr;
  logic             kx_busy;
  logic [RK_AW-1:0] raddr, rnum;
  logic [BLK_W-1:0] rkey;
  logic [BLK_W-1:0] round_out;
  logic             accept, load_out;

  // Round key schedule and store.
  avfc_kexp u_kexp (
    .clk  (clk),
    .rst_n(rst_n),
    .cfg  (cfg_wr),
    .wr   (rk_wr),
    .busy (kx_busy)
  );

  avfc_ram #(.WIDTH(BLK_W), .DEPTH(NUM_RK)) u_rk_ram (
    .clk  (clk),
    .we   (rk_wr.en),
    .waddr(rk_wr.addr),
    .wdata(rk_wr.data),
    .raddr(raddr),
    .rdata(rkey)
  );

  avfc_round u_round (
    .state_in (blk_r),
    .rkey     (rkey),
    .dec      (dec_r),
    .last     (rnd_r == LAST_RND),
    .state_out(round_out)
  );

  assign in_req.ready = (st_r == ST_IDLE) && !kx_busy;
  assign accept       = in_req.valid && in_req.ready;
  assign load_out     = (st_r == ST_OUT) && (!out_valid_r || out_rsp.ready);

  // Key fetch runs one round ahead; decrypt walks the schedule backwards.
  always_comb begin
    st_nxt  = st_r;
    rnd_nxt = rnd_r;
    rnum    = '0;
    raddr   = '0;
    case (st_r)
      ST_IDLE: begin
        raddr = in_req.op ? LAST_RND : '0;
        if (accept) st_nxt = ST_WHITEN;
      end
      ST_WHITEN: begin
        rnum    = RK_AW'(1);
        raddr   = dec_r ? LAST_RND - rnum : rnum;
        rnd_nxt = RK_AW'(1);
        st_nxt  = ST_ROUND;
      end
      ST_ROUND: begin
        rnum    = (rnd_r == LAST_RND) ? rnd_r : rnd_r + 1'b1;
        raddr   = dec_r ? LAST_RND - rnum : rnum;
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == LAST_RND) st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (load_out) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      rnd_r <= rnd_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_rsp.ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath: load, whiten, then one round per cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      blk_r <= {in_req.block_high, in_req.block_low};
      dec_r <= in_req.op;
    end else if (st_r == ST_WHITEN) begin
      blk_r <= blk_r ^ rkey;
    end else if (st_r == ST_ROUND) begin
      blk_r <= round_out;
    end
    if (load_out) out_data_r <= blk_r;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.result_high = out_data_r[127:64];
  assign out_rsp.result_low  = out_data_r[63:0];

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_ROUND |-> (rnd_r >= RK_AW'(1) && rnd_r <= LAST_RND))
    else $error("round counter out of range");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ROUND && rnd_r == LAST_RND) |=> st_r == ST_OUT)
    else $error("final round did not hand off to output");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == ST_OUT))
    else $error("result raised without a finished block");
endmodule

### rtl/avfc_ram.sv
module avfc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/avfc_kexp.sv
module avfc_kexp (
  input  logic            clk,
  input  logic            rst_n,
  avfc_cfg_if.sink        cfg,
  output avfc_pkg::rk_wr_t wr,
  output logic            busy
);
  import avfc_pkg::*;

  logic [HALF_W-1:0] key_hi_r, key_lo_r;
  logic              busy_r;
  logic [RK_AW-1:0]  step_r;
  logic [BLK_W-1:0]  cur_r;
  logic [7:0]        rc_r;
  logic [BLK_W-1:0]  next_rk;
  logic [31:0]       w0, w1, w2, w3, t, n0, n1, n2, n3;
  logic              hit;

  assign cfg.ready = 1'b1;
  assign hit = cfg.valid && (cfg.index == REG_KEY_HIGH || cfg.index == REG_KEY_LOW);

  always_comb begin
    w0 = cur_r[127:96];
    w1 = cur_r[95:64];
    w2 = cur_r[63:32];
    w3 = cur_r[31:0];
    // rotate, substitute, fold in the round constant
    t  = {FWD_SBOX[w3[23:16]] ^ rc_r, FWD_SBOX[w3[15:8]],
          FWD_SBOX[w3[7:0]], FWD_SBOX[w3[31:24]]};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    next_rk = {n0, n1, n2, n3};
  end

  assign wr.en   = busy_r;
  assign wr.addr = step_r;
  assign wr.data = (step_r == '0) ? {key_hi_r, key_lo_r} : next_rk;
  assign busy    = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      busy_r   <= 1'b0;
      step_r   <= '0;
    end else if (hit) begin
      if (cfg.index == REG_KEY_HIGH) key_hi_r <= cfg.data;
      else key_lo_r <= cfg.data;
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == LAST_RND) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && !hit) begin
      cur_r <= wr.data;
      rc_r  <= (step_r == '0) ? RCON_INIT : xtime(rc_r);
    end
  end
endmodule

### rtl/avfc_round.sv
module avfc_round (
  input  logic [127:0] state_in,
  input  logic [127:0] rkey,
  input  logic         dec,
  input  logic         last,
  output logic [127:0] state_out
);
  import avfc_pkg::*;

  function automatic logic [7:0] gb(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] rows_rot(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127-8*(4*c+r) -: 8] = gb(s, 4 * ((inv ? (c + 4 - r) : (c + r)) % 4) + r);
    return o;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0] m [4];
    logic [7:0] acc;
    o = '0;
    if (inv) begin
      m[0] = 8'h0E; m[1] = 8'h0B; m[2] = 8'h0D; m[3] = 8'h09;
    end else begin
      m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
    end
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++)
          acc = acc ^ gf_mul(gb(s, 4 * c + k), m[(k + 4 - r) % 4]);
        o[127-8*(4*c+r) -: 8] = acc;
      end
    return o;
  endfunction

  logic [127:0] sub_e, sh_e, mx_e, sh_d, sub_d, ak_d;

  always_comb begin
    for (int i = 0; i < 16; i++)
      sub_e[127-8*i -: 8] = FWD_SBOX[state_in[127-8*i -: 8]];
    sh_e = rows_rot(sub_e, 1'b0);
    mx_e = last ? sh_e : mix_cols(sh_e, 1'b0);

    sh_d = rows_rot(state_in, 1'b1);
    for (int i = 0; i < 16; i++)
      sub_d[127-8*i -: 8] = REV_SBOX[sh_d[127-8*i -: 8]];
    ak_d = sub_d ^ rkey;

    state_out = dec ? (last ? ak_d : mix_cols(ak_d, 1'b1)) : (mx_e ^ rkey);
  end
endmodule

### bench/avfc_checker.sv
`timescale 1ns / 100ps

module avfc_checker (
  input  logic clk,
  input  logic rst_n,
  avfc_in_if   in_mon,
  avfc_out_if  out_mon,
  avfc_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending
);
  import avfc_pkg::*;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  typedef logic [7:0] state_t [16];

  logic [63:0] key_hi;
  logic [63:0] key_lo;
  logic [7:0]  sched [176];
  logic [7:0]  fwd_tab [256];
  logic [7:0]  inv_tab [256];
  block_t      cipher_out_q [$];

  function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = a[7] ? ({a[6:0], 1'b0} ^ FIELD_LOW) : {a[6:0], 1'b0};
    end
    return acc;
  endfunction

  // a^254 by repeated squaring
  function automatic logic [7:0] finv(input logic [7:0] a);
    logic [7:0] acc;
    logic [7:0] sq;
    acc = 8'h01;
    sq  = a;
    for (int i = 0; i < 7; i++) begin
      sq  = fmul(sq, sq);
      acc = fmul(acc, sq);
    end
    return acc;
  endfunction

  function automatic logic [7:0] rl(input logic [7:0] x, input int n);
    return 8'((x << n) | (x >> (8 - n)));
  endfunction

  initial begin
    logic [7:0] y;
    logic [7:0] x;
    for (int i = 0; i < 256; i++) begin
      x = i[7:0];
      y = finv(x);
      fwd_tab[i] = y ^ rl(y, 1) ^ rl(y, 2) ^ rl(y, 3) ^ rl(y, 4) ^ FWD_AFF;
      inv_tab[i] = finv(rl(x, 1) ^ rl(x, 3) ^ rl(x, 6) ^ INV_AFF);
    end
  end

  task automatic expand_schedule();
    logic [7:0] w [4];
    logic [7:0] rc;
    logic [7:0] f;
    rc = RCON_INIT;
    for (int n = 0; n < 8; n++) begin
      sched[n]     = key_hi[63-8*n -: 8];
      sched[8 + n] = key_lo[63-8*n -: 8];
    end
    for (int n = 16; n < 176; n += 4) begin
      for (int j = 0; j < 4; j++) w[j] = sched[n - 4 + j];
      if (n % 16 == 0) begin
        f    = w[0];
        w[0] = fwd_tab[w[1]] ^ rc;
        w[1] = fwd_tab[w[2]];
        w[2] = fwd_tab[w[3]];
        w[3] = fwd_tab[f];
        rc   = rc[7] ? ({rc[6:0], 1'b0} ^ FIELD_LOW) : {rc[6:0], 1'b0};
      end
      for (int j = 0; j < 4; j++) sched[n + j] = sched[n - 16 + j] ^ w[j];
    end
  endtask

  function automatic void add_rk(ref state_t s, input int rnd);
    for (int i = 0; i < 16; i++) s[i] ^= sched[rnd * 16 + i];
  endfunction

  function automatic void sub_state(ref state_t s, input logic inv);
    for (int i = 0; i < 16; i++) s[i] = inv ? inv_tab[s[i]] : fwd_tab[s[i]];
  endfunction

  function automatic void rows_rot(ref state_t s, input logic inv);
    state_t t;
    t = s;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        s[4*c + r] = t[4*(inv ? ((c + 4 - r) % 4) : ((c + r) % 4)) + r];
  endfunction

  function automatic void mix_cols(ref state_t s, input logic inv);
    logic [7:0] m [4];
    logic [7:0] acc;
    state_t     t;
    if (inv) m = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
    else     m = '{8'h02, 8'h03, 8'h01, 8'h01};
    t = s;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) acc ^= fmul(m[(k + 4 - r) % 4], t[4*c + k]);
        s[4*c + r] = acc;
      end
  endfunction

  function automatic block_t run_cipher(input logic dec, input logic [63:0] hi,
                                        input logic [63:0] lo);
    state_t s;
    block_t b;
    for (int n = 0; n < 8; n++) begin
      s[n]     = hi[63-8*n -: 8];
      s[8 + n] = lo[63-8*n -: 8];
    end
    if (!dec) begin
      add_rk(s, 0);
      for (int n = 1; n <= 9; n++) begin
        sub_state(s, 1'b0);
        rows_rot(s, 1'b0);
        mix_cols(s, 1'b0);
        add_rk(s, n);
      end
      sub_state(s, 1'b0);
      rows_rot(s, 1'b0);
      add_rk(s, 10);
    end else begin
      add_rk(s, 10);
      for (int n = 9; n >= 1; n--) begin
        rows_rot(s, 1'b1);
        sub_state(s, 1'b1);
        add_rk(s, n);
        mix_cols(s, 1'b1);
      end
      rows_rot(s, 1'b1);
      sub_state(s, 1'b1);
      add_rk(s, 0);
    end
    for (int n = 0; n < 8; n++) begin
      b.hi[63-8*n -: 8] = s[n];
      b.lo[63-8*n -: 8] = s[8 + n];
    end
    return b;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    block_t want;
    if (!rst_n) begin
      key_hi = '0;
      key_lo = '0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        // out-of-range indexes leave the key untouched
        if (cfg_mon.index == REG_KEY_HIGH || cfg_mon.index == REG_KEY_LOW) begin
          if (cfg_mon.index == REG_KEY_HIGH) key_hi = cfg_mon.data;
          else                               key_lo = cfg_mon.data;
          expand_schedule();
        end
      end
      if (in_mon.valid && in_mon.ready)
        cipher_out_q.push_back(run_cipher(in_mon.op, in_mon.block_high, in_mon.block_low));
      if (out_mon.valid && out_mon.ready) begin
        if (cipher_out_q.size() == 0) begin
          report_mismatch("unexpected result", '0, out_mon.result_high);
        end else begin
          want = cipher_out_q.pop_front();
          if (out_mon.result_high !== want.hi)
            report_mismatch("result_high", want.hi, out_mon.result_high);
          if (out_mon.result_low !== want.lo)
            report_mismatch("result_low", want.lo, out_mon.result_low);
        end
      end
      pending = cipher_out_q.size();
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import avfc_pkg::*;

  localparam int STALL_LIMIT = 3000;

  logic clk;
  logic rst_n;
  logic quiet;
  int   fail_count;
  int   pending;
  int   stall_cycles;

  avfc_in_if  in_req ();
  avfc_out_if out_rsp ();
  avfc_cfg_if cfg_wr ();

  aes128_variant_field_cipher_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg_wr)
  );

  avfc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_req),
    .out_mon    (out_rsp),
    .cfg_mon    (cfg_wr),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Drop ready about 17% of the time, except during the quiet stretch.
  always @(negedge clk) begin
    out_rsp.ready = quiet ? 1'b1 : ($urandom_range(99) >= 17);
  end

  // Watchdog: end the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Write one key register; hold valid until the block takes it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_wr.valid = 1'b1;
    cfg_wr.index = idx;
    cfg_wr.data  = val;
    do @(posedge clk); while (!cfg_wr.ready);
    @(negedge clk);
    cfg_wr.valid = 1'b0;
  endtask

  // Send one request; an optional idle gap comes first. Valid stays high
  // back to back when there is no gap.
  task automatic send_block(input logic dec, input logic [63:0] hi, input logic [63:0] lo);
    int gap;
    gap = (!quiet && $urandom_range(99) < 17) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_req.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_req.valid      = 1'b1;
    in_req.op         = dec;
    in_req.block_high = hi;
    in_req.block_low  = lo;
    do @(posedge clk); while (!in_req.ready);
  endtask

  // Lower valid, then wait until every request has come back plus some slack
  // so the block is idle before the next key write.
  task automatic drain();
    @(negedge clk);
    in_req.valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_half();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Directed corner blocks for both directions.
  task automatic corner_blocks();
    logic [63:0] pats [4];
    pats = '{64'h0, '1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};
    for (int p = 0; p < 4; p++) begin
      send_block(1'b0, pats[p], pats[3 - p]);
      send_block(1'b1, pats[p], pats[p]);
    end
  endtask

  task automatic random_blocks(input int count);
    for (int i = 0; i < count; i++)
      send_block(1'($urandom_range(1)), rand_half(), rand_half());
  endtask

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    quiet             = 1'b0;
    stall_cycles      = 0;
    in_req.valid      = 1'b0;
    in_req.op         = 1'b0;
    in_req.block_high = '0;
    in_req.block_low  = '0;
    out_rsp.ready     = 1'b0;
    cfg_wr.valid      = 1'b0;
    cfg_wr.index      = '0;
    cfg_wr.data       = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // All-zero key, then the all-ones key, each with the corner blocks.
    write_reg(REG_KEY_HIGH, '0);
    write_reg(REG_KEY_LOW, '0);
    corner_blocks();
    drain();
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW, '1);
    corner_blocks();
    // Out-of-range indexes must not disturb the key.
    drain();
    write_reg(8'd2, {$urandom, $urandom});
    write_reg(8'hFF, {$urandom, $urandom});
    corner_blocks();

    // Random keys; one phase runs with no idling on either side.
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(REG_KEY_HIGH, rand_half());
      write_reg(REG_KEY_LOW, rand_half());
      quiet = (ph == 2);
      random_blocks(260);
    end
    quiet = 1'b0;

    drain();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
